>>> rtl/rws_pkg.sv
package rws_pkg;

   // request codes
   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_SELECT = 2'd1;
   localparam logic [1:0] MODE_TAKE = 2'd2;

   // fixed field widths of the ports
   localparam int MODE_W = 2;
   localparam int INDEX_W = 7;
   localparam int WVAL_W = 16;
   localparam int DRAW_W = 23;
   localparam int TOTAL_W = 23;
   localparam int CSR_W = 8;

   // reported total saturates here
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = 23'h7FFFFF;

   // scan length after reset
   localparam logic [CSR_W-1:0] ENTRIES_RESET = 8'd100;

endpackage

>>> rtl/roulette_wheel_selector_core.sv
// channel   | ports                                         | handshake
// ----------+-----------------------------------------------+-----------------------------
// request   | req_mode, req_entry_index, req_weight_value,  | taken when start & !busy
//           | req_random_draw                               |
// response  | rsp_chosen_index, rsp_not_found,              | one cycle, marked rsp_strobe
//           | rsp_weight_total                              |
// csr       | csr_write_data                                | written when csr_write_enable
//
// from the accepting edge to the response: a select walks the weights in order
//   (up to the scan length) and then reports, a take also retires the weight,
//   a write swaps the weight in the total, an early miss or an unused mode replies via S_REPLY
// the walk is set by the single read port of the weight memory and one shared adder
// reset: after reset the block sweeps the memory to zero, busy high
// stalls: the receiver cannot stall, each response is shown for exactly one cycle

module roulette_wheel_selector_core #(
   parameter int TABLE_DEPTH = 128,
   parameter int WEIGHT_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [rws_pkg::MODE_W-1:0]    req_mode,
   input  logic [rws_pkg::INDEX_W-1:0]   req_entry_index,
   input  logic [rws_pkg::WVAL_W-1:0]    req_weight_value,
   input  logic [rws_pkg::DRAW_W-1:0]    req_random_draw,
   output logic                          rsp_strobe,
   output logic [rws_pkg::INDEX_W-1:0]   rsp_chosen_index,
   output logic                          rsp_not_found,
   output logic [rws_pkg::TOTAL_W-1:0]   rsp_weight_total,
   input  logic                          csr_write_enable,
   input  logic [rws_pkg::CSR_W-1:0]     csr_write_data
);

   // widths that follow from the table size
   localparam int ADDR_BITS = $clog2(TABLE_DEPTH);
   localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);
   localparam int SUM_BITS = WEIGHT_BITS + ADDR_BITS;
   // datapath width: covers both the exact sum and the draw
   localparam int DW = (SUM_BITS > rws_pkg::DRAW_W) ? SUM_BITS : rws_pkg::DRAW_W;
   localparam int AW = DW + 1;
   localparam int IDXW = (CNT_BITS > rws_pkg::INDEX_W) ? CNT_BITS : rws_pkg::INDEX_W;
   localparam int LENW = (CNT_BITS > rws_pkg::CSR_W) ? CNT_BITS : rws_pkg::CSR_W;
   localparam int WW = (WEIGHT_BITS > rws_pkg::WVAL_W) ? WEIGHT_BITS : rws_pkg::WVAL_W;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_REPLY,
      S_SCAN,
      S_TAKE,
      S_WR_SUB,
      S_WR_ADD
   } state_type;

   // sequencer and datapath registers
   state_type                     state_ff, state_in;
   logic [ADDR_BITS-1:0]          ptr_ff, ptr_in;
   logic [DW-1:0]                 draw_ff, draw_in;
   logic [SUM_BITS-1:0]           total_ff, total_in;
   logic [rws_pkg::MODE_W-1:0]    mode_ff, mode_in;
   logic [WEIGHT_BITS-1:0]        wval_ff, wval_in;
   logic [rws_pkg::CSR_W-1:0]     entries_ff;
   logic                          rsp_strobe_ff, rsp_strobe_in;
   logic [rws_pkg::INDEX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic                          rsp_miss_ff, rsp_miss_in;
   logic [rws_pkg::TOTAL_W-1:0]   rsp_total_ff, rsp_total_in;

   // weight memory, one write and one registered read port
   logic [WEIGHT_BITS-1:0]        weight_mem [TABLE_DEPTH];
   logic [WEIGHT_BITS-1:0]        rdata_ff;
   logic                          mem_we;
   logic [ADDR_BITS-1:0]          mem_waddr;
   logic [WEIGHT_BITS-1:0]        mem_wdata;
   logic [ADDR_BITS-1:0]          mem_raddr;

   // the shared add / subtract unit, borrow doubles as the compare
   logic [DW-1:0]                 alu_a, alu_b;
   logic                          alu_sub;
   logic [AW-1:0]                 alu_res;
   logic                          alu_borrow;

   // helpers
   logic [IDXW-1:0]               idx_ext;
   logic                          idx_in_range;
   logic [LENW-1:0]               cfg_ext;
   logic [LENW-1:0]               scan_len;
   logic                          scan_last;
   logic [ADDR_BITS-1:0]          ptr_next;
   logic [WEIGHT_BITS-1:0]        wval_masked;
   logic [rws_pkg::TOTAL_W-1:0]   total_now_sat;
   logic [rws_pkg::TOTAL_W-1:0]   alu_sat;
   logic [IDXW-1:0]               ptr_ext;

   assign alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b}) : ({1'b0, alu_a} + {1'b0, alu_b});
   assign alu_borrow = alu_res[AW-1];

   assign idx_ext = IDXW'(req_entry_index);
   assign idx_in_range = idx_ext < IDXW'(TABLE_DEPTH);
   assign wval_masked = WEIGHT_BITS'(WW'(req_weight_value));

   // scan length clamped to the table
   assign cfg_ext = LENW'(entries_ff);
   assign scan_len = (cfg_ext > LENW'(TABLE_DEPTH)) ? LENW'(TABLE_DEPTH) : cfg_ext;
   assign scan_last = (LENW'(ptr_ff) + LENW'(1)) == scan_len;
   assign ptr_next = ptr_ff + ADDR_BITS'(1);
   assign ptr_ext = IDXW'(ptr_ff);

   // saturated views of the total for the response
   assign total_now_sat = (DW'(total_ff) > DW'(rws_pkg::TOTAL_MAX)) ?
                          rws_pkg::TOTAL_MAX : rws_pkg::TOTAL_W'(DW'(total_ff));
   assign alu_sat = (alu_res[DW-1:0] > DW'(rws_pkg::TOTAL_MAX)) ?
                    rws_pkg::TOTAL_MAX : rws_pkg::TOTAL_W'(alu_res[DW-1:0]);

   assign busy = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_chosen_index = rsp_index_ff;
   assign rsp_not_found = rsp_miss_ff;
   assign rsp_weight_total = rsp_total_ff;

   always_comb begin
      state_in = state_ff;
      ptr_in = ptr_ff;
      draw_in = draw_ff;
      total_in = total_ff;
      mode_in = mode_ff;
      wval_in = wval_ff;
      rsp_strobe_in = 1'b0;
      rsp_index_in = rsp_index_ff;
      rsp_miss_in = rsp_miss_ff;
      rsp_total_in = rsp_total_ff;
      mem_we = 1'b0;
      mem_waddr = ptr_ff;
      mem_wdata = '0;
      mem_raddr = ptr_ff;
      alu_a = DW'(total_ff);
      alu_b = '0;
      alu_sub = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            // sweep zeros through the memory after reset
            mem_we = 1'b1;
            ptr_in = ptr_next;
            if (ptr_ff == ADDR_BITS'(TABLE_DEPTH - 1)) begin
               ptr_in = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            // compare the draw against the total
            alu_a = DW'(req_random_draw);
            alu_b = DW'(total_ff);
            alu_sub = 1'b1;
            if (start) begin
               mode_in = req_mode;
               rsp_index_in = '0;
               rsp_miss_in = 1'b0;
               rsp_total_in = total_now_sat;
               case (req_mode)
                  rws_pkg::MODE_WRITE: begin
                     if (idx_in_range) begin
                        ptr_in = idx_ext[ADDR_BITS-1:0];
                        mem_raddr = idx_ext[ADDR_BITS-1:0];
                        wval_in = wval_masked;
                        state_in = S_WR_SUB;
                     end else begin
                        state_in = S_REPLY;
                     end
                  end
                  rws_pkg::MODE_SELECT, rws_pkg::MODE_TAKE: begin
                     if (!alu_borrow || scan_len == '0) begin
                        rsp_miss_in = 1'b1;
                        state_in = S_REPLY;
                     end else begin
                        ptr_in = '0;
                        mem_raddr = '0;
                        draw_in = DW'(req_random_draw);
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     state_in = S_REPLY;
                  end
               endcase
            end
         end
         S_REPLY: begin
            rsp_strobe_in = 1'b1;
            state_in = S_IDLE;
         end
         S_SCAN: begin
            // one weight per cycle, next one already being read
            alu_a = draw_ff;
            alu_b = DW'(rdata_ff);
            alu_sub = 1'b1;
            mem_raddr = ptr_next;
            if (alu_borrow) begin
               if (mode_ff == rws_pkg::MODE_TAKE) begin
                  draw_in = DW'(rdata_ff);
                  state_in = S_TAKE;
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_index_in = ptr_ext[rws_pkg::INDEX_W-1:0];
                  rsp_miss_in = 1'b0;
                  rsp_total_in = total_now_sat;
                  state_in = S_IDLE;
               end
            end else begin
               draw_in = alu_res[DW-1:0];
               if (scan_last) begin
                  // rest of the sum lies beyond the scanned entries
                  rsp_strobe_in = 1'b1;
                  rsp_index_in = '0;
                  rsp_miss_in = 1'b1;
                  rsp_total_in = total_now_sat;
                  state_in = S_IDLE;
               end else begin
                  ptr_in = ptr_next;
               end
            end
         end
         S_TAKE: begin
            // retire the chosen weight
            alu_a = DW'(total_ff);
            alu_b = draw_ff;
            alu_sub = 1'b1;
            total_in = alu_res[SUM_BITS-1:0];
            mem_we = 1'b1;
            rsp_strobe_in = 1'b1;
            rsp_index_in = ptr_ext[rws_pkg::INDEX_W-1:0];
            rsp_miss_in = 1'b0;
            rsp_total_in = alu_sat;
            state_in = S_IDLE;
         end
         S_WR_SUB: begin
            alu_a = DW'(total_ff);
            alu_b = DW'(rdata_ff);
            alu_sub = 1'b1;
            total_in = alu_res[SUM_BITS-1:0];
            state_in = S_WR_ADD;
         end
         S_WR_ADD: begin
            alu_a = DW'(total_ff);
            alu_b = DW'(wval_ff);
            total_in = alu_res[SUM_BITS-1:0];
            mem_we = 1'b1;
            mem_wdata = wval_ff;
            rsp_strobe_in = 1'b1;
            rsp_index_in = '0;
            rsp_miss_in = 1'b0;
            rsp_total_in = alu_sat;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ptr_ff <= '0;
         total_ff <= '0;
         entries_ff <= rws_pkg::ENTRIES_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ptr_ff <= ptr_in;
         total_ff <= total_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_write_enable) begin
            entries_ff <= csr_write_data;
         end
      end
      draw_ff <= draw_in;
      mode_ff <= mode_in;
      wval_ff <= wval_in;
      rsp_index_ff <= rsp_index_in;
      rsp_miss_ff <= rsp_miss_in;
      rsp_total_ff <= rsp_total_in;
   end

   // weight memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         weight_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= weight_mem[mem_raddr];
   end

   // an accepted request always makes the block busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted without going busy");

   // responses never come in adjacent cycles
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two responses back to back");

   // the walk stays inside the scanned range
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (LENW'(ptr_ff) < scan_len))
      else $error("scan pointer beyond scan length");

   // a response follows only from busy work
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response without a request in flight");

endmodule

>>> tb/sv/tb_roulette_wheel_selector_core.sv
module tb_roulette_wheel_selector_core;

   // block size, matches the defaults of the core
   localparam int TABLE_DEPTH = 128;
   localparam int WEIGHT_BITS = 16;

   // the one request code that the package leaves unnamed
   localparam logic [rws_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

   // idle cycles allowed with no request taken and no response seen: reset sweep,
   // longest sender gap and a full walk of the table, several times over
   localparam int STALL_LIMIT = 2000;
   // quiet time after the last response, about one full walk
   localparam int END_SETTLE = TABLE_DEPTH + 8;
   // longest sender gap
   localparam int GAP_MAX = 150;

   typedef struct packed {
      logic [rws_pkg::INDEX_W-1:0] chosen;
      logic                        miss;
      logic [rws_pkg::TOTAL_W-1:0] total;
   } pick_type;

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic [rws_pkg::MODE_W-1:0]   req_mode;
   logic [rws_pkg::INDEX_W-1:0]  req_entry_index;
   logic [rws_pkg::WVAL_W-1:0]   req_weight_value;
   logic [rws_pkg::DRAW_W-1:0]   req_random_draw;
   logic                         rsp_strobe;
   logic [rws_pkg::INDEX_W-1:0]  rsp_chosen_index;
   logic                         rsp_not_found;
   logic [rws_pkg::TOTAL_W-1:0]  rsp_weight_total;
   logic                         csr_write_enable;
   logic [rws_pkg::CSR_W-1:0]    csr_write_data;

   // own copy of the wheel: weights, exact sum and scan length
   logic [WEIGHT_BITS-1:0]    wheel_weight [0:TABLE_DEPTH-1];
   int unsigned               wheel_sum;
   logic [rws_pkg::CSR_W-1:0] scan_cfg;

   // picks still owed by the core, oldest first
   pick_type pending_picks [$];

   // sender idling on or off
   bit idle_enable;

   int unsigned mismatches;
   int unsigned stall_cycles;
   int unsigned n_write, n_select, n_take, n_unused, n_hit, n_miss, n_scan_writes;

   roulette_wheel_selector_core #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .WEIGHT_BITS(WEIGHT_BITS)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_entry_index  (req_entry_index),
      .req_weight_value (req_weight_value),
      .req_random_draw  (req_random_draw),
      .rsp_strobe       (rsp_strobe),
      .rsp_chosen_index (rsp_chosen_index),
      .rsp_not_found    (rsp_not_found),
      .rsp_weight_total (rsp_weight_total),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // predictor: applies one request to the wheel copy and returns the pick
   // ---------------------------------------------------------------------------
   function automatic pick_type spin_wheel(logic [rws_pkg::MODE_W-1:0] mode,
                                           logic [rws_pkg::INDEX_W-1:0] idx,
                                           logic [rws_pkg::WVAL_W-1:0] wval,
                                           logic [rws_pkg::DRAW_W-1:0] draw);
      pick_type    res;
      int unsigned scan_len;
      int unsigned remaining;
      int unsigned j;
      bit          hit;
      res = '0;
      hit = 1'b0;
      case (mode)
         rws_pkg::MODE_WRITE: begin
            // table is exactly 128 deep, so every 7-bit index lands
            wheel_sum = wheel_sum - 32'(wheel_weight[idx]) + 32'(wval);
            wheel_weight[idx] = wval;
            n_write++;
         end
         rws_pkg::MODE_SELECT, rws_pkg::MODE_TAKE: begin
            // scan length saturates at the table depth, zero scans nothing
            scan_len = (32'(scan_cfg) > TABLE_DEPTH) ? TABLE_DEPTH : 32'(scan_cfg);
            remaining = 32'(draw);
            if (wheel_sum != 0 && 32'(draw) < wheel_sum) begin
               for (j = 0; j < scan_len && !hit; j++) begin
                  if (remaining < 32'(wheel_weight[j])) begin
                     hit = 1'b1;
                     res.chosen = j[rws_pkg::INDEX_W-1:0];
                  end else begin
                     remaining = remaining - 32'(wheel_weight[j]);
                  end
               end
            end
            if (hit) begin
               // a take retires the chosen weight
               if (mode == rws_pkg::MODE_TAKE) begin
                  wheel_sum = wheel_sum - 32'(wheel_weight[res.chosen]);
                  wheel_weight[res.chosen] = '0;
               end
               n_hit++;
            end else begin
               // empty wheel, short wheel or scan ended early
               res.miss = 1'b1;
               res.chosen = '0;
               n_miss++;
            end
            if (mode == rws_pkg::MODE_TAKE) n_take++;
            else n_select++;
         end
         default: n_unused++;
      endcase
      res.total = (wheel_sum > 32'(rws_pkg::TOTAL_MAX)) ? rws_pkg::TOTAL_MAX
                                                        : wheel_sum[rws_pkg::TOTAL_W-1:0];
      return res;
   endfunction

   // ---------------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------------

   // drives one request after an optional random gap, returns once it is taken;
   // start is left high so a following request goes out without a dead cycle
   task automatic send_request(logic [rws_pkg::MODE_W-1:0] mode,
                               logic [rws_pkg::INDEX_W-1:0] idx,
                               logic [rws_pkg::WVAL_W-1:0] wval,
                               logic [rws_pkg::DRAW_W-1:0] draw);
      int unsigned gap;
      pick_type    owed;
      @(negedge clock);
      if (idle_enable && $urandom_range(0, 99) < 38) begin
         // mostly short gaps, now and then a longer one of up to GAP_MAX
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(40, GAP_MAX)
                                           : $urandom_range(1, 20);
         start = 1'b0;
         req_mode = rws_pkg::MODE_W'($urandom);
         req_entry_index = rws_pkg::INDEX_W'($urandom);
         req_weight_value = rws_pkg::WVAL_W'($urandom);
         req_random_draw = rws_pkg::DRAW_W'($urandom);
         repeat (gap) @(negedge clock);
      end
      start = 1'b1;
      req_mode = mode;
      req_entry_index = idx;
      req_weight_value = wval;
      req_random_draw = draw;
      @(posedge clock);
      while (busy) @(posedge clock);
      owed = spin_wheel(mode, idx, wval, draw);
      pending_picks.insert(pending_picks.size(), owed);
   endtask

   // holds the sender off until every pick is back and the core is idle
   task automatic wait_drained();
      @(negedge clock);
      start = 1'b0;
      while (pending_picks.size() != 0) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // scan length register, only written with the core idle
   task automatic set_scan_length(logic [rws_pkg::CSR_W-1:0] value);
      wait_drained();
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      csr_write_data = rws_pkg::CSR_W'($urandom);
      scan_cfg = value;
      n_scan_writes++;
   endtask

   function automatic logic [rws_pkg::WVAL_W-1:0] pick_weight();
      logic [rws_pkg::WVAL_W-1:0] w;
      case ($urandom_range(0, 9))
         0: w = '0;
         1: w = '1;
         2, 3, 4, 5: w = rws_pkg::WVAL_W'($urandom_range(1, 15));
         default: w = rws_pkg::WVAL_W'($urandom);
      endcase
      return w;
   endfunction

   // one random request; writes land mostly inside the scanned range and
   // draws mostly below the current sum so that selects reach deep entries
   task automatic random_request(bit write_only);
      int unsigned roll;
      int unsigned top;
      logic [rws_pkg::MODE_W-1:0]  m;
      logic [rws_pkg::INDEX_W-1:0] ix;
      logic [rws_pkg::WVAL_W-1:0]  w;
      logic [rws_pkg::DRAW_W-1:0]  d;
      roll = write_only ? 0 : $urandom_range(0, 99);
      ix = rws_pkg::INDEX_W'($urandom);
      w = pick_weight();
      d = rws_pkg::DRAW_W'($urandom);
      top = (scan_cfg == 0) ? TABLE_DEPTH - 1
                            : ((32'(scan_cfg) > TABLE_DEPTH) ? TABLE_DEPTH
                                                             : 32'(scan_cfg)) - 1;
      if ($urandom_range(0, 9) != 0) ix = rws_pkg::INDEX_W'($urandom_range(0, top));
      if (wheel_sum != 0 && $urandom_range(0, 9) != 0)
         d = rws_pkg::DRAW_W'($urandom_range(0, wheel_sum - 1));
      if (roll < 30) m = rws_pkg::MODE_WRITE;
      else if (roll < 60) m = rws_pkg::MODE_SELECT;
      else if (roll < 88) m = rws_pkg::MODE_TAKE;
      else if (roll < 93) m = MODE_UNUSED;
      else m = rws_pkg::MODE_W'($urandom);   // noise: any code, any fields
      send_request(m, ix, w, d);
   endtask

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // empty wheel, unused code, extreme weights, draws at the edges of each slot
   task automatic test_empty_wheel();
      send_request(rws_pkg::MODE_SELECT, 7'd0, 16'd0, 23'd0);     // nothing stored yet
      send_request(rws_pkg::MODE_TAKE, 7'd0, 16'd0, 23'd0);
      send_request(MODE_UNUSED, 7'h7F, 16'hFFFF, 23'h7FFFFF);
      send_request(rws_pkg::MODE_WRITE, 7'd0, 16'hFFFF, 23'd0);
      send_request(rws_pkg::MODE_WRITE, 7'h7F, 16'hFFFF, 23'h7FFFFF); // beyond reset scan
      send_request(rws_pkg::MODE_WRITE, 7'd5, 16'd1, 23'd0);
      send_request(rws_pkg::MODE_SELECT, 7'd0, 16'd0, 23'd0);
      send_request(rws_pkg::MODE_SELECT, 7'd0, 16'd0, 23'd65534);
      send_request(rws_pkg::MODE_SELECT, 7'd0, 16'd0, 23'd65535);
      send_request(rws_pkg::MODE_SELECT, 7'd0, 16'd0, 23'd65536); // scan ends early
      send_request(rws_pkg::MODE_SELECT, 7'd0, 16'd0, 23'h7FFFFF); // draw above the sum
   endtask

   // scan length at its extremes: full table, above the table, zero and one
   task automatic test_scan_limit();
      set_scan_length(8'd128);
      send_request(rws_pkg::MODE_SELECT, 7'd0, 16'd0, 23'd65536);
      set_scan_length(8'd255);
      send_request(rws_pkg::MODE_SELECT, 7'd0, 16'd0, 23'd131070);
      set_scan_length(8'd0);
      send_request(rws_pkg::MODE_SELECT, 7'd0, 16'd0, 23'd0);
      set_scan_length(8'd1);
      send_request(rws_pkg::MODE_SELECT, 7'd0, 16'd0, 23'd65535);
      send_request(rws_pkg::MODE_SELECT, 7'd0, 16'd0, 23'd0);
   endtask

   // takes drain the wheel one entry at a time until it is empty
   task automatic test_take_until_empty();
      set_scan_length(8'd128);
      send_request(rws_pkg::MODE_TAKE, 7'd0, 16'd0, 23'd65535);
      send_request(rws_pkg::MODE_TAKE, 7'd0, 16'd0, 23'd0);
      send_request(rws_pkg::MODE_TAKE, 7'd0, 16'd0, 23'd0);
      send_request(rws_pkg::MODE_SELECT, 7'd0, 16'd0, 23'd0);
      send_request(rws_pkg::MODE_WRITE, 7'd3, 16'd0, 23'd0);      // zero weight write
   endtask

   // random phases, each at its own scan length; fill first, then mixed traffic
   task automatic test_random_traffic();
      logic [rws_pkg::CSR_W-1:0] scan_plan [9];
      int unsigned               p;
      int unsigned               k;
      int unsigned               phase_len;
      scan_plan = '{8'd128, 8'd1, 8'd255, 8'd2, 8'd37, rws_pkg::ENTRIES_RESET, 8'd0, 8'd64,
                    8'd200};
      scan_plan[4] = rws_pkg::CSR_W'($urandom_range(3, 127));
      scan_plan[8] = rws_pkg::CSR_W'($urandom_range(129, 254));
      for (p = 0; p < 9; p++) begin
         set_scan_length(scan_plan[p]);
         // one long stretch with the sender never idling
         idle_enable = (p != 3);
         phase_len = (scan_plan[p] == 0) ? 40 : 126;
         for (k = 0; k < phase_len; k++) begin
            // sender holds off until everything owed has come back
            if (p == 0 && k == phase_len / 2) wait_drained();
            random_request(k < 12);
         end
      end
      idle_enable = 1'b1;
   endtask

   // ---------------------------------------------------------------------------
   // response checking, against the oldest pick owed
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : check_response
      pick_type want;
      if (!reset && rsp_strobe) begin
         if (pending_picks.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t unexpected response: index %0d not_found %0b total %0d",
                        $realtime, rsp_chosen_index, rsp_not_found, rsp_weight_total);
         end else begin
            want = pending_picks.pop_front();
            if (rsp_chosen_index !== want.chosen || rsp_not_found !== want.miss ||
                rsp_weight_total !== want.total) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t mismatch: index exp %0d got %0d,",
                           $realtime, want.chosen, rsp_chosen_index,
                           " not_found exp %0b got %0b, total exp %0d got %0d",
                           want.miss, rsp_not_found, want.total, rsp_weight_total);
            end
         end
      end
   end

   // watchdog: cycles with neither a request taken nor a response shown
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: nothing moved for %0d cycles, %0d responses owed",
                     stall_cycles, pending_picks.size());
            $display("tb_roulette_wheel_selector_core: FAIL");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------
   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_mode = rws_pkg::MODE_WRITE;
      req_entry_index = '0;
      req_weight_value = '0;
      req_random_draw = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      idle_enable = 1'b1;
      mismatches = 0;
      stall_cycles = 0;
      n_write = 0; n_select = 0; n_take = 0; n_unused = 0;
      n_hit = 0; n_miss = 0; n_scan_writes = 0;
      // wheel copy starts cleared, as the core is after its sweep
      foreach (wheel_weight[i]) wheel_weight[i] = '0;
      wheel_sum = 0;
      scan_cfg = rws_pkg::ENTRIES_RESET;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // the first request simply waits out the clearing sweep on busy
      test_empty_wheel();
      test_scan_limit();
      test_take_until_empty();
      test_random_traffic();

      wait_drained();
      repeat (END_SETTLE) @(posedge clock);

      $display("covered %0d writes, %0d selects, %0d takes, %0d unused codes;",
               n_write, n_select, n_take, n_unused, " %0d hits, %0d misses", n_hit, n_miss);
      $display("scan length written %0d times; %0d mismatches", n_scan_writes, mismatches);
      if (mismatches == 0 && pending_picks.size() == 0) begin
         $display("tb_roulette_wheel_selector_core: PASS");
      end else begin
         $display("tb_roulette_wheel_selector_core: FAIL");
      end
      $finish;
   end

endmodule
